### rtl/core/pva_pkg.sv
// Shared constants, types and tables for the polar vector adder.
`default_nettype none
package pva_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_STAGES = 32;

  localparam logic [15:0] FULL_UNITS = 16'd46080;
  localparam logic [15:0] Q1_UNITS   = 16'd11520;
  localparam logic [15:0] Q2_UNITS   = 16'd23040;
  localparam logic [15:0] Q3_UNITS   = 16'd34560;

  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;
  localparam logic [15:0] INV_GAIN_HI = 16'h9B74;
  localparam logic [15:0] INV_GAIN_LO = 16'hEDA8;

  // quotient / remainder by 45
  localparam logic [10:0] RECIP_45 = 11'd1456;
  localparam int DIV_BASE = 45;

  typedef logic [21:0] rtab_t [DIV_BASE];

  // (r * 2^22 + 22) / 45 for each remainder r
  function automatic rtab_t mk_rtab();
    rtab_t t;
    for (int r = 0; r < DIV_BASE; r++) begin
      t[r] = 22'((longint'(r) * 64'd4194304 + 64'd22) / DIV_BASE);
    end
    return t;
  endfunction

  localparam rtab_t REM_TAB = mk_rtab();

  // atan(2^-i), full turn = 2^32
  function automatic logic [29:0] atan_angle(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0:  a = 30'h20000000;
      5'd1:  a = 30'h12E4051E;
      5'd2:  a = 30'h09FB385B;
      5'd3:  a = 30'h051111D4;
      5'd4:  a = 30'h028B0D43;
      5'd5:  a = 30'h0145D7E1;
      5'd6:  a = 30'h00A2F61E;
      5'd7:  a = 30'h00517C55;
      5'd8:  a = 30'h0028BE53;
      5'd9:  a = 30'h00145F2F;
      5'd10: a = 30'h000A2F98;
      5'd11: a = 30'h000517CC;
      5'd12: a = 30'h00028BE6;
      5'd13: a = 30'h000145F3;
      5'd14: a = 30'h0000A2FA;
      5'd15: a = 30'h0000517D;
      5'd16: a = 30'h000028BE;
      5'd17: a = 30'h0000145F;
      5'd18: a = 30'h00000A30;
      5'd19: a = 30'h00000518;
      5'd20: a = 30'h0000028C;
      5'd21: a = 30'h00000146;
      5'd22: a = 30'h000000A3;
      5'd23: a = 30'h00000051;
      5'd24: a = 30'h00000029;
      5'd25: a = 30'h00000014;
      5'd26: a = 30'h0000000A;
      5'd27: a = 30'h00000005;
      5'd28: a = 30'h00000003;
      5'd29: a = 30'h00000001;
      5'd30: a = 30'h00000001;
      default: a = 30'h00000000;
    endcase
    return a;
  endfunction

  typedef struct packed {
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic        [32:0] z;
    logic        [1:0]  quad;
    logic               axis;
    logic        [1:0]  axq;
    logic        [23:0] mag;
  } rot_t;

  typedef struct packed {
    logic        [39:0] x;
    logic        [39:0] y;
    logic        [33:0] z;
    logic               near;
    logic               axis;
    logic               sxn;
    logic               syn;
    logic        [24:0] amag;
    logic        [15:0] adir;
  } vec_t;

endpackage
`default_nettype wire

### rtl/core/pva_in_if.sv
// Input channel: a pair of polar vectors.
`default_nettype none
interface pva_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] a_magnitude;
  logic [15:0] a_direction;
  logic [23:0] b_magnitude;
  logic [15:0] b_direction;
  modport source (output valid, a_magnitude, a_direction, b_magnitude, b_direction,
                  input ready);
  modport sink   (input valid, a_magnitude, a_direction, b_magnitude, b_direction,
                  output ready);
endinterface
`default_nettype wire

### rtl/core/pva_out_if.sv
// Output channel: the sum vector in polar form.
`default_nettype none
interface pva_out_if;
  logic        valid;
  logic        ready;
  logic [24:0] sum_magnitude;
  logic [15:0] sum_direction;
  modport source (output valid, sum_magnitude, sum_direction, input ready);
  modport sink   (input valid, sum_magnitude, sum_direction, output ready);
endinterface
`default_nettype wire

### rtl/core/pva_resolve.sv
// Polar to cartesian: angle conversion, pipelined rotation CORDIC, quadrant map.
`default_nettype none
module pva_resolve #(
  parameter int NS = pva_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic [23:0]        mag,
  input  logic [15:0]        dir,
  output logic signed [36:0] px,
  output logic signed [36:0] py
);
  import pva_pkg::*;

  logic [15:0] a_dir;
  logic [31:0] a_x0;
  logic [23:0] a_mag;
  logic [55:0] x0_prod;

  assign x0_prod = 56'(mag) * 56'(INV_GAIN);

  always_ff @(posedge clk) begin
    if (en) begin
      a_dir <= (dir >= FULL_UNITS) ? dir - FULL_UNITS : dir;
      a_x0  <= x0_prod[55:24];
      a_mag <= mag;
    end
  end

  // binary angle = round(dir * 2^32 / 46080)
  logic [26:0] qp;
  logic [9:0]  q0;
  logic [15:0] r0;
  logic [9:0]  qd;
  logic [5:0]  rd;
  logic [31:0] ang;
  rot_t        init;

  always_comb begin
    qp = 27'(a_dir) * 27'(RECIP_45);
    q0 = qp[25:16];
    r0 = a_dir - 16'(q0 * 16'd45);
    if (r0 >= 16'd45) begin
      qd = q0 + 10'd1;
      rd = 6'(r0 - 16'd45);
    end else begin
      qd = q0;
      rd = 6'(r0);
    end
    ang = {qd, 22'd0} + {10'd0, REM_TAB[rd]};
    init.x    = {4'd0, a_x0};
    init.y    = '0;
    init.z    = {3'd0, ang[29:0]};
    init.quad = ang[31:30];
    init.axis = (a_dir == 16'd0) || (a_dir == Q1_UNITS) ||
                (a_dir == Q2_UNITS) || (a_dir == Q3_UNITS);
    if (a_dir == Q1_UNITS) init.axq = 2'd1;
    else if (a_dir == Q2_UNITS) init.axq = 2'd2;
    else if (a_dir == Q3_UNITS) init.axq = 2'd3;
    else init.axq = 2'd0;
    init.mag  = a_mag;
  end

  rot_t st [NS+1];

  always_ff @(posedge clk) begin
    if (en) st[0] <= init;
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    rot_t nxt;
    logic signed [35:0] xs, ys;
    always_comb begin
      nxt = st[i];
      xs  = $signed(st[i].x) >>> i;
      ys  = $signed(st[i].y) >>> i;
      if (!st[i].z[32]) begin
        nxt.x = st[i].x - ys;
        nxt.y = st[i].y + xs;
        nxt.z = st[i].z - {3'd0, atan_angle(5'(i))};
      end else begin
        nxt.x = st[i].x + ys;
        nxt.y = st[i].y - xs;
        nxt.z = st[i].z + {3'd0, atan_angle(5'(i))};
      end
    end
    always_ff @(posedge clk) begin
      if (en) st[i+1] <= nxt;
    end
  end

  logic signed [36:0] m, fx, fy;
  logic signed [36:0] ox, oy;

  always_comb begin
    m  = {5'd0, st[NS].mag, 8'd0};
    fx = {st[NS].x[35], st[NS].x};
    fy = {st[NS].y[35], st[NS].y};
    if (st[NS].axis) begin
      case (st[NS].axq)
        2'd0:    begin ox = m;    oy = '0;   end
        2'd1:    begin ox = '0;   oy = m;    end
        2'd2:    begin ox = -m;   oy = '0;   end
        default: begin ox = '0;   oy = -m;   end
      endcase
    end else begin
      case (st[NS].quad)
        2'd0:    begin ox = fx;   oy = fy;   end
        2'd1:    begin ox = -fy;  oy = fx;   end
        2'd2:    begin ox = -fx;  oy = -fy;  end
        default: begin ox = fy;   oy = -fx;  end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px <= ox;
      py <= oy;
    end
  end

endmodule
`default_nettype wire

### rtl/core/polar_vector_adder_unit.sv
// Top level: adds two polar vectors through pipelined CORDIC stages.
//
//  channel   | dir | payload
//  operands  | in  | a_magnitude, a_direction, b_magnitude, b_direction
//  result    | out | sum_magnitude, sum_direction
//
// One item per cycle while result is not stalled; the pipeline is made of the
// rotation and vectoring CORDIC pipelines plus conversion stages.
// rst clears the valid bits only. A stall on result freezes every stage
// together; operands.ready follows that shared enable.
`default_nettype none
module polar_vector_adder_unit #(
  parameter int CORDIC_STAGES = pva_pkg::CORDIC_STAGES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pva_in_if.sink    operands,
  pva_out_if.source result
);
  import pva_pkg::*;

  localparam int NS  = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
  localparam int LAT = 2 * NS + 7;

  localparam logic [32:0] HALF_TURN  = 33'h080000000;
  localparam logic [32:0] WHOLE_TURN = 33'h100000000;
  localparam logic [30:0] QTR_TURN   = 31'h40000000;

  function automatic logic [24:0] to_out_mag(input logic [37:0] v);
    logic [38:0] r;
    r = ({1'b0, v} + 39'd128) >> 8;
    return (r > 39'h1FFFFFF) ? 25'h1FFFFFF : r[24:0];
  endfunction

  logic           en;
  logic [LAT-1:0] vld;

  assign en = !vld[LAT-1] || result.ready;
  assign operands.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], operands.valid};
    end
  end

  logic signed [36:0] xa, ya, xb, yb;

  pva_resolve #(.NS(NS)) u_res_a (
    .clk(clk), .en(en), .mag(operands.a_magnitude), .dir(operands.a_direction),
    .px(xa), .py(ya)
  );

  pva_resolve #(.NS(NS)) u_res_b (
    .clk(clk), .en(en), .mag(operands.b_magnitude), .dir(operands.b_direction),
    .px(xb), .py(yb)
  );

  logic signed [37:0] sx, sy;

  always_ff @(posedge clk) begin
    if (en) begin
      sx <= {xa[36], xa} + {xb[36], xb};
      sy <= {ya[36], ya} + {yb[36], yb};
    end
  end

  logic [37:0] ax, ay;
  vec_t        vinit;

  always_comb begin
    ax = sx[37] ? 38'(-sx) : 38'(sx);
    ay = sy[37] ? 38'(-sy) : 38'(sy);
    vinit.x    = {2'd0, ax};
    vinit.y    = {2'd0, ay};
    vinit.z    = '0;
    vinit.near = (ax < 38'd256) && (ay < 38'd256);
    vinit.axis = (sy == '0) || (sx == '0);
    vinit.sxn  = sx[37];
    vinit.syn  = sy[37];
    if (sy == '0) begin
      vinit.amag = to_out_mag(ax);
      vinit.adir = sx[37] ? Q2_UNITS : 16'd0;
    end else begin
      vinit.amag = to_out_mag(ay);
      vinit.adir = sy[37] ? Q3_UNITS : Q1_UNITS;
    end
  end

  vec_t vs [NS+1];

  always_ff @(posedge clk) begin
    if (en) vs[0] <= vinit;
  end

  for (genvar i = 0; i < NS; i++) begin : g_vec
    vec_t nxt;
    logic [39:0] xs, ys;
    always_comb begin
      nxt = vs[i];
      xs  = 40'($signed(vs[i].x) >>> i);
      ys  = 40'($signed(vs[i].y) >>> i);
      if (!vs[i].y[39] && vs[i].y != '0) begin
        nxt.x = vs[i].x + ys;
        nxt.y = vs[i].y - xs;
        nxt.z = vs[i].z + {4'd0, atan_angle(5'(i))};
      end else begin
        nxt.x = vs[i].x - ys;
        nxt.y = vs[i].y + xs;
        nxt.z = vs[i].z - {4'd0, atan_angle(5'(i))};
      end
    end
    always_ff @(posedge clk) begin
      if (en) vs[i+1] <= nxt;
    end
  end

  // gain removal and quadrant fix
  logic [38:0] xc;
  logic [30:0] zc;
  logic [32:0] zq_c;
  logic [54:0] ph, pl;
  logic [32:0] zq;
  logic        f_near, f_axis;
  logic [24:0] f_amag;
  logic [15:0] f_adir;

  always_comb begin
    xc = vs[NS].x[39] ? '0 : vs[NS].x[38:0];
    if (vs[NS].z[33]) zc = '0;
    else if (vs[NS].z[32:0] > {2'd0, QTR_TURN}) zc = QTR_TURN;
    else zc = vs[NS].z[30:0];
    if (!vs[NS].sxn && !vs[NS].syn) zq_c = {2'd0, zc};
    else if (vs[NS].sxn && !vs[NS].syn) zq_c = HALF_TURN - {2'd0, zc};
    else if (vs[NS].sxn) zq_c = HALF_TURN + {2'd0, zc};
    else zq_c = WHOLE_TURN - {2'd0, zc};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph     <= 55'(xc) * 55'(INV_GAIN_HI);
      pl     <= 55'(xc) * 55'(INV_GAIN_LO);
      zq     <= zq_c;
      f_near <= vs[NS].near;
      f_axis <= vs[NS].axis;
      f_amag <= vs[NS].amag;
      f_adir <= vs[NS].adir;
    end
  end

  logic [55:0] prod;
  logic [55:0] rnd;
  logic [24:0] gmag;
  logic [49:0] up;
  logic [17:0] ud;
  logic [15:0] gdir;
  logic [24:0] mag_c;
  logic [15:0] dir_c;

  always_comb begin
    prod = {1'b0, ph} + {17'd0, pl[54:16]};
    rnd  = (prod + 56'h800000) >> 24;
    gmag = (rnd > 56'h1FFFFFF) ? 25'h1FFFFFF : rnd[24:0];
    up   = 50'(zq) * 50'(FULL_UNITS) + 50'h80000000;
    ud   = up[49:32];
    gdir = (ud >= 18'(FULL_UNITS)) ? 16'(ud - 18'(FULL_UNITS)) : ud[15:0];
    if (f_near) begin
      mag_c = '0;
      dir_c = '0;
    end else if (f_axis) begin
      mag_c = f_amag;
      dir_c = f_adir;
    end else begin
      mag_c = gmag;
      dir_c = gdir;
    end
  end

  logic [24:0] o_mag;
  logic [15:0] o_dir;

  always_ff @(posedge clk) begin
    if (en) begin
      o_mag <= mag_c;
      o_dir <= dir_c;
    end
  end

  assign result.valid         = vld[LAT-1];
  assign result.sum_magnitude = o_mag;
  assign result.sum_direction = o_dir;

endmodule
`default_nettype wire

### sim/polar_vector_adder_unit_tb.sv
// Testbench for the polar vector adder: fixed-point polar sum predictor, directed and random stimulus.
`default_nettype none
module polar_vector_adder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES = pva_pkg::CORDIC_STAGES_DEF;
  localparam int LATENCY = 2 * STAGES + 7;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint FULL_TURN_U = 46080;
  localparam longint QUARTER_U = 11520;
  localparam longint INV_K = 64'h9B74EDA8;
  localparam longint QUARTER_ANG = 64'h40000000;
  localparam longint HALF_ANG = 64'h80000000;
  localparam longint WHOLE_ANG = 64'h100000000;
  localparam logic [23:0] MAX_MAG = 24'hFFFFFF;
  localparam int MAX_DIR = 46079;

  typedef struct packed {
    logic [23:0] a_mag;
    logic [15:0] a_dir;
    logic [23:0] b_mag;
    logic [15:0] b_dir;
  } vec_pair_t;

  typedef struct packed {
    logic [24:0] mag;
    logic [15:0] dir;
  } polar_sum_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pva_in_if operands();
  pva_out_if result();

  polar_vector_adder_unit #(.CORDIC_STAGES(STAGES)) u_top (
    .clk(clk), .rst(rst), .operands(operands.sink), .result(result.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  vec_pair_t pending_pairs[$];
  polar_sum_t expected_sums[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_sender = 1'b0;
  int errors = 0;
  int sums_checked = 0;
  int pairs_sent = 0;
  longint cycles = 0;

  function automatic longint arith_shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint atan_step(int i);
    return longint'(pva_pkg::atan_angle(5'(i)));
  endfunction

  function automatic void resolve_parts(longint mag, longint dir, output longint px,
                                        output longint py);
    longint m, ang, x, y, z, xs, ys;
    int q;
    m = mag << 8;
    if (dir >= FULL_TURN_U) dir -= FULL_TURN_U;
    if (dir % QUARTER_U == 0) begin
      q = int'(dir / QUARTER_U);
      px = (q == 0) ? m : ((q == 2) ? -m : 0);
      py = (q == 1) ? m : ((q == 3) ? -m : 0);
      return;
    end
    ang = ((dir << 32) + FULL_TURN_U / 2) / FULL_TURN_U;
    q = int'((ang >> 30) & 3);
    x = (mag * INV_K) >> 24;
    y = 0;
    z = ang & 64'h3FFFFFFF;
    for (int i = 0; i < STAGES; i++) begin
      xs = arith_shr(x, i);
      ys = arith_shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_step(i);
      end else begin
        x += ys; y -= xs; z += atan_step(i);
      end
    end
    case (q)
      0: begin px = x; py = y; end
      1: begin px = -y; py = x; end
      2: begin px = -x; py = -y; end
      default: begin px = y; py = -x; end
    endcase
  endfunction

  function automatic longint sat_mag(longint v);
    return (v > 64'h1FFFFFF) ? 64'h1FFFFFF : v;
  endfunction

  function automatic polar_sum_t predict_sum(vec_pair_t p);
    longint xa, ya, xb, yb, sx, sy, ax, ay, x, y, z, xs, ys, prod, d;
    polar_sum_t r;
    resolve_parts(p.a_mag, p.a_dir, xa, ya);
    resolve_parts(p.b_mag, p.b_dir, xb, yb);
    sx = xa + xb;
    sy = ya + yb;
    ax = sx < 0 ? -sx : sx;
    ay = sy < 0 ? -sy : sy;
    if (ax < 256 && ay < 256) begin
      r.mag = '0; r.dir = '0;
    end else if (sy == 0) begin
      r.mag = 25'(sat_mag((ax + 128) >> 8));
      r.dir = sx > 0 ? 16'd0 : 16'(2 * QUARTER_U);
    end else if (sx == 0) begin
      r.mag = 25'(sat_mag((ay + 128) >> 8));
      r.dir = sy > 0 ? 16'(QUARTER_U) : 16'(3 * QUARTER_U);
    end else begin
      x = ax; y = ay; z = 0;
      for (int i = 0; i < STAGES; i++) begin
        xs = arith_shr(x, i);
        ys = arith_shr(y, i);
        if (y > 0) begin
          x += ys; y -= xs; z += atan_step(i);
        end else begin
          x -= ys; y += xs; z -= atan_step(i);
        end
      end
      if (x < 0) x = 0;
      prod = x * (INV_K >> 16) + ((x * (INV_K & 64'hFFFF)) >> 16);
      prod = (prod + (64'd1 << 23)) >> 24;
      r.mag = 25'(sat_mag(prod));
      if (z < 0) z = 0;
      if (z > QUARTER_ANG) z = QUARTER_ANG;
      if (sx > 0 && sy > 0) z = z;
      else if (sx < 0 && sy > 0) z = HALF_ANG - z;
      else if (sx < 0) z = HALF_ANG + z;
      else z = WHOLE_ANG - z;
      d = (z * FULL_TURN_U + 64'h80000000) >> 32;
      if (d >= FULL_TURN_U) d -= FULL_TURN_U;
      r.dir = 16'(d);
    end
    return r;
  endfunction

  function automatic logic [23:0] rand_mag();
    case ($urandom_range(0, 5))
      0: return 24'($urandom_range(0, 3));
      1: return 24'($urandom_range(0, 1023));
      2: return MAX_MAG;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(0, 7))
      0: return 16'(QUARTER_U * $urandom_range(0, 3));
      1: return 16'($urandom_range(46080, 65535));
      2: return 16'(QUARTER_U * $urandom_range(0, 3) + $urandom_range(0, 2) - 1);
      default: return 16'($urandom_range(0, MAX_DIR));
    endcase
  endfunction

  function automatic vec_pair_t rand_pair();
    vec_pair_t p;
    p.a_mag = rand_mag();
    p.a_dir = rand_dir();
    if ($urandom_range(0, 4) == 0) begin
      // opposite or equal vector: cancellation and near-zero sums
      p.b_mag = p.a_mag + 24'($urandom_range(0, 2));
      p.b_dir = 16'((17'(p.a_dir) % 17'd46080 + 17'd23040) % 17'd46080);
      if ($urandom_range(0, 1) == 1) p.b_dir = p.a_dir;
    end else begin
      p.b_mag = rand_mag();
      p.b_dir = rand_dir();
    end
    return p;
  endfunction

  task automatic add_pair(logic [23:0] am, logic [15:0] ad, logic [23:0] bm,
                          logic [15:0] bd);
    pending_pairs.push_back({am, ad, bm, bd});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      operands.valid <= 1'b0;
    end else if (!operands.valid || operands.ready) begin
      if (operands.valid) begin
        expected_sums.push_back(predict_sum({operands.a_magnitude, operands.a_direction,
                                             operands.b_magnitude, operands.b_direction}));
        pairs_sent++;
      end
      if (pending_pairs.size() > 0 && !hold_sender &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        vec_pair_t p;
        p = pending_pairs.pop_front();
        operands.valid <= 1'b1;
        operands.a_magnitude <= p.a_mag;
        operands.a_direction <= p.a_dir;
        operands.b_magnitude <= p.b_mag;
        operands.b_direction <= p.b_dir;
      end else begin
        operands.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: unexpected result mag=%0d dir=%0d", $time,
                   result.sum_magnitude, result.sum_direction);
          errors++;
        end else begin
          polar_sum_t e;
          e = expected_sums.pop_front();
          sums_checked++;
          if (result.sum_magnitude !== e.mag) begin
            $display("%0t: sum_magnitude expected %0d got %0d", $time, e.mag,
                     result.sum_magnitude);
            errors++;
          end
          if (result.sum_direction !== e.dir) begin
            $display("%0t: sum_direction expected %0d got %0d", $time, e.dir,
                     result.sum_direction);
            errors++;
          end
        end
      end
      result.ready <= $urandom_range(0, 99) >= recv_stall_pct;
    end
  end

  initial begin
    operands.valid = 1'b0;
    operands.a_magnitude = '0;
    operands.a_direction = '0;
    operands.b_magnitude = '0;
    operands.b_direction = '0;
    result.ready = 1'b0;
    wait (cycles >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  task automatic run_phase(int idle_pct, int stall_pct, int n);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) pending_pairs.push_back(rand_pair());
    while (pending_pairs.size() > 0 || operands.valid) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    add_pair('0, '0, '0, '0);
    add_pair(MAX_MAG, 16'd0, MAX_MAG, 16'd0);
    add_pair(MAX_MAG, 16'(MAX_DIR), MAX_MAG, 16'd1);
    add_pair(MAX_MAG, 16'hFFFF, MAX_MAG, 16'hB400);
    add_pair(24'd1000, 16'd0, 24'd1000, 16'd23040);
    add_pair(24'd1000, 16'd11520, 24'd1000, 16'd34560);
    add_pair(24'd500, 16'd11520, 24'd0, 16'd0);
    add_pair(24'd500, 16'd23040, 24'd3, 16'd34560);
    add_pair(24'd500, 16'd34560, 24'd0, 16'd46080);
    add_pair(24'd1, 16'd100, 24'd0, 16'd0);
    add_pair(24'd256, 16'd5760, 24'd256, 16'd17280);
    add_pair(24'd256, 16'd28800, 24'd256, 16'd40320);
    add_pair(24'd12345, 16'd46079, 24'd6789, 16'd1);
    add_pair(24'hAAAAAA, 16'h5555, 24'h555555, 16'hAAAA);
    add_pair(24'd4096, 16'd1000, 24'd4096, 16'd24040);
    add_pair(MAX_MAG, 16'd11519, 24'd0, 16'd0);

    run_phase(0, 0, 200);
    run_phase(52, 0, 200);
    hold_sender = 1'b1;
    while (expected_sums.size() > 0) @(posedge clk);
    hold_sender = 1'b0;
    run_phase(0, 52, 200);
    run_phase(10, 10, 230);

    while (expected_sums.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d sums from %0d vector pairs across idle/stall phases.",
             sums_checked, pairs_sent);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
